[hw/rtl/ure_pkg.sv]
package ure_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned MAX_RESULTS = 11;

  localparam logic [7:0] CH_APOS    = 8'h27;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;
  localparam logic [7:0] CH_LF      = 8'h0a;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_N       = 8'h6e;
  localparam logic [7:0] CH_R       = 8'h72;
  localparam logic [7:0] CH_T       = 8'h74;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_LOW_U   = 8'h75;
  localparam logic [7:0] CH_HIGH_U  = 8'h55;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] CH_DEL     = 8'h7f;

  localparam int NP_COUNT = 24;

  localparam logic [20:0] NP_LO [NP_COUNT] = '{
    21'h0007f, 21'h000ad, 21'h00600, 21'h0061c, 21'h006dd, 21'h0070f,
    21'h00890, 21'h008e2, 21'h01680, 21'h0180e, 21'h02000, 21'h02028,
    21'h0205f, 21'h02066, 21'h03000, 21'h0feff, 21'h0fff9, 21'h110bd,
    21'h110cd, 21'h13430, 21'h1bca0, 21'h1d173, 21'he0001, 21'he0020
  };

  localparam logic [20:0] NP_HI [NP_COUNT] = '{
    21'h000a0, 21'h000ad, 21'h00605, 21'h0061c, 21'h006dd, 21'h0070f,
    21'h00891, 21'h008e2, 21'h01680, 21'h0180e, 21'h0200f, 21'h0202f,
    21'h02064, 21'h0206f, 21'h03000, 21'h0feff, 21'h0fffb, 21'h110bd,
    21'h110cd, 21'h1343f, 21'h1bca3, 21'h1d17a, 21'he0001, 21'he007f
  };

  typedef enum logic [2:0] {
    PH_OPEN,
    PH_FLA,
    PH_MAIN,
    PH_FLB,
    PH_CLOSE
  } phase_t;

  // One request's worth of output, in emission order:
  // open quote, held bytes of a broken sequence, main part, flush at end, close quote.
  typedef struct packed {
    logic            open_en;
    logic [7:0]      quote;
    logic [1:0]      fa_cnt;
    logic [2:0][7:0] fa_bytes;
    logic            main_hex;
    logic [3:0]      main_len;
    logic [3:0][7:0] lit_bytes;
    logic [7:0]      hex_letter;
    logic [20:0]     hex_val;
    logic [1:0]      fb_cnt;
    logic [2:0][7:0] fb_bytes;
    logic            close_en;
    logic [3:0]      res_cnt;
  } job_t;

  function automatic logic is_nonprint(input logic [20:0] cp);
    logic hit;
    hit = (cp < 21'(CTRL_LIMIT));
    for (int i = 0; i < NP_COUNT; i++) begin
      if (cp >= NP_LO[i] && cp <= NP_HI[i]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'h0, nib};
    end else begin
      ch = 8'h57 + {4'h0, nib};
    end
    return ch;
  endfunction

endpackage

[hw/rtl/ure_front.sv]
module ure_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_accept,
  input  logic [7:0]    data_byte,
  input  logic          byte_present,
  input  logic          starts_string,
  input  logic          ends_string,
  input  logic          use_double_quote,
  output ure_pkg::job_t job,
  output logic          job_push
);
  import ure_pkg::*;

  logic [7:0]      lead_r, lead_nxt;
  logic [1:0][7:0] cont_r, cont_nxt;
  logic [1:0]      need_r, need_nxt;
  logic [1:0]      coll_r, coll_nxt;
  logic [20:0]     acc_r, acc_nxt;
  logic            quote_r, quote_nxt;

  logic [7:0]      qch;
  logic [1:0]      s_need, s_coll;
  logic [20:0]     s_acc;
  logic [7:0]      s_lead;
  logic [1:0]      p_need, p_coll;
  logic [20:0]     p_acc;
  logic [7:0]      p_lead;
  logic [20:0]     acc_shift;
  logic [1:0]      fa_cnt;
  logic            main_hex;
  logic [20:0]     hex_src;
  logic [3:0]      lit_len;
  logic [3:0][7:0] lit_bytes;
  logic [3:0]      hex_len;
  logic [7:0]      hex_letter;
  logic [3:0]      main_len;
  logic [1:0]      fb_cnt;
  logic [4:0]      total;

  assign quote_nxt = starts_string ? use_double_quote : quote_r;
  assign qch       = quote_nxt ? CH_DQUOTE : CH_APOS;

  // a start drops whatever sequence the previous string left pending
  assign s_need = starts_string ? 2'd0 : need_r;
  assign s_coll = starts_string ? 2'd0 : coll_r;
  assign s_acc  = starts_string ? 21'd0 : acc_r;
  assign s_lead = starts_string ? 8'd0 : lead_r;

  assign acc_shift = {s_acc[14:0], data_byte[5:0]};

  always_comb begin
    p_need    = s_need;
    p_coll    = s_coll;
    p_acc     = s_acc;
    p_lead    = s_lead;
    cont_nxt  = cont_r;
    fa_cnt    = 2'd0;
    main_hex  = 1'b0;
    hex_src   = 21'd0;
    lit_len   = 4'd0;
    lit_bytes = '0;
    if (byte_present) begin
      if (s_need != 2'd0 && data_byte[7:6] == 2'b10) begin
        if ({1'b0, s_coll} + 3'd1 < {1'b0, s_need}) begin
          cont_nxt[s_coll[0]] = data_byte;
          p_coll = s_coll + 2'd1;
          p_acc  = acc_shift;
        end else begin
          if (is_nonprint(acc_shift)) begin
            main_hex = 1'b1;
            hex_src  = acc_shift;
          end else begin
            lit_bytes[0] = s_lead;
            lit_bytes[1] = (s_coll == 2'd0) ? data_byte : cont_r[0];
            lit_bytes[2] = (s_coll == 2'd1) ? data_byte : cont_r[1];
            lit_bytes[3] = data_byte;
            lit_len      = {2'b00, s_coll} + 4'd2;
          end
          p_need = 2'd0;
          p_coll = 2'd0;
          p_acc  = 21'd0;
          p_lead = 8'd0;
        end
      end else begin
        if (s_need != 2'd0) begin
          fa_cnt = s_coll + 2'd1;
        end
        p_need = 2'd0;
        p_coll = 2'd0;
        p_acc  = 21'd0;
        p_lead = 8'd0;
        priority if (data_byte == qch || data_byte == CH_BSLASH) begin
          lit_bytes[0] = CH_BSLASH;
          lit_bytes[1] = data_byte;
          lit_len      = 4'd2;
        end else if (data_byte == CH_LF) begin
          lit_bytes[0] = CH_BSLASH;
          lit_bytes[1] = CH_N;
          lit_len      = 4'd2;
        end else if (data_byte == CH_CR) begin
          lit_bytes[0] = CH_BSLASH;
          lit_bytes[1] = CH_R;
          lit_len      = 4'd2;
        end else if (data_byte == CH_TAB) begin
          lit_bytes[0] = CH_BSLASH;
          lit_bytes[1] = CH_T;
          lit_len      = 4'd2;
        end else if (!data_byte[7]) begin
          if (data_byte < CTRL_LIMIT || data_byte == CH_DEL) begin
            main_hex = 1'b1;
            hex_src  = {13'd0, data_byte};
          end else begin
            lit_bytes[0] = data_byte;
            lit_len      = 4'd1;
          end
        end else if (data_byte[7:5] == 3'b110) begin
          p_need = 2'd1;
          p_acc  = {16'd0, data_byte[4:0]};
          p_lead = data_byte;
        end else if (data_byte[7:4] == 4'b1110) begin
          p_need = 2'd2;
          p_acc  = {17'd0, data_byte[3:0]};
          p_lead = data_byte;
        end else if (data_byte[7:3] == 5'b11110) begin
          p_need = 2'd3;
          p_acc  = {18'd0, data_byte[2:0]};
          p_lead = data_byte;
        end else begin
          lit_bytes[0] = data_byte;
          lit_len      = 4'd1;
        end
      end
    end
  end

  always_comb begin
    if (hex_src < 21'h100) begin
      hex_len    = 4'd4;
      hex_letter = CH_X;
    end else if (hex_src < 21'h10000) begin
      hex_len    = 4'd6;
      hex_letter = CH_LOW_U;
    end else begin
      hex_len    = 4'd10;
      hex_letter = CH_HIGH_U;
    end
  end

  assign main_len = main_hex ? hex_len : lit_len;
  assign fb_cnt   = (ends_string && p_need != 2'd0) ? p_coll + 2'd1 : 2'd0;

  // flush at end of string clears the pending sequence
  assign need_nxt = ends_string ? 2'd0 : p_need;
  assign coll_nxt = ends_string ? 2'd0 : p_coll;
  assign acc_nxt  = ends_string ? 21'd0 : p_acc;
  assign lead_nxt = ends_string ? 8'd0 : p_lead;

  assign total = {4'd0, starts_string} + {3'd0, fa_cnt} + {1'b0, main_len}
               + {3'd0, fb_cnt} + {4'd0, ends_string};

  always_comb begin
    job.open_en    = starts_string;
    job.quote      = qch;
    job.fa_cnt     = fa_cnt;
    job.fa_bytes   = {cont_r[1], cont_r[0], s_lead};
    job.main_hex   = main_hex;
    job.main_len   = main_len;
    job.lit_bytes  = lit_bytes;
    job.hex_letter = hex_letter;
    job.hex_val    = hex_src;
    job.fb_cnt     = fb_cnt;
    job.fb_bytes   = {cont_nxt[1], cont_nxt[0], p_lead};
    job.close_en   = ends_string;
    job.res_cnt    = (total > 5'(MAX_RESULTS)) ? 4'(MAX_RESULTS) : total[3:0];
  end

  assign job_push = in_accept && (total != 5'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r  <= 8'd0;
      need_r  <= 2'd0;
      coll_r  <= 2'd0;
      acc_r   <= 21'd0;
      quote_r <= 1'b0;
    end else if (in_accept) begin
      lead_r  <= lead_nxt;
      need_r  <= need_nxt;
      coll_r  <= coll_nxt;
      acc_r   <= acc_nxt;
      quote_r <= quote_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cont_r <= cont_nxt;
    end
  end

endmodule

[hw/rtl/ure_queue.sv]
module ure_queue #(
  parameter int unsigned DEPTH = ure_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ure_pkg::job_t push_job,
  input  logic          pop,
  output ure_pkg::job_t head_job,
  output logic          head_valid,
  output logic          full
);
  import ure_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign head_job   = slot_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign full       = (count_r == CNT_W'(DEPTH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[hw/rtl/ure_back.sv]
module ure_back (
  input  logic          clk,
  input  logic          rst_n,
  input  ure_pkg::job_t job,
  input  logic          job_valid,
  output logic          job_pop,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [7:0]    out_char,
  output logic          out_run_last,
  output logic          out_string_done
);
  import ure_pkg::*;

  phase_t          phase_r, phase_nxt;
  phase_t          cur_phase;
  phase_t          succ_phase;
  logic [3:0]      idx_r, idx_nxt;
  logic [3:0]      cnt_r, cnt_nxt;
  logic [3:0]      seg_ne;
  logic [3:0]      cur_len;
  logic            load;
  logic            last;
  logic [2:0]      nib_pos;
  logic [7:0][3:0] hex_nibs;
  logic [7:0]      byte_sel;

  logic            out_valid_r;
  logic [7:0]      out_char_r;
  logic            run_last_r;
  logic            string_done_r;

  assign seg_ne = {job.fb_cnt != 2'd0, job.main_len != 4'd0,
                   job.fa_cnt != 2'd0, job.open_en};

  // skip empty segments ahead of the stored phase
  always_comb begin
    priority if (phase_r == PH_OPEN && seg_ne[0]) begin
      cur_phase = PH_OPEN;
    end else if (phase_r <= PH_FLA && seg_ne[1]) begin
      cur_phase = PH_FLA;
    end else if (phase_r <= PH_MAIN && seg_ne[2]) begin
      cur_phase = PH_MAIN;
    end else if (phase_r <= PH_FLB && seg_ne[3]) begin
      cur_phase = PH_FLB;
    end else begin
      cur_phase = PH_CLOSE;
    end
  end

  always_comb begin
    unique case (cur_phase)
      PH_OPEN:  cur_len = {3'd0, job.open_en};
      PH_FLA:   cur_len = {2'd0, job.fa_cnt};
      PH_MAIN:  cur_len = job.main_len;
      PH_FLB:   cur_len = {2'd0, job.fb_cnt};
      PH_CLOSE: cur_len = {3'd0, job.close_en};
      default:  cur_len = 4'd0;
    endcase
  end

  always_comb begin
    unique case (cur_phase)
      PH_OPEN:  succ_phase = PH_FLA;
      PH_FLA:   succ_phase = PH_MAIN;
      PH_MAIN:  succ_phase = PH_FLB;
      PH_FLB:   succ_phase = PH_CLOSE;
      default:  succ_phase = PH_CLOSE;
    endcase
  end

  assign load    = job_valid && (!out_valid_r || out_ready);
  assign last    = (cnt_r == job.res_cnt - 4'd1);
  assign job_pop = load && last;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    if (load) begin
      if (last) begin
        phase_nxt = PH_OPEN;
        idx_nxt   = 4'd0;
        cnt_nxt   = 4'd0;
      end else if ({1'b0, idx_r} + 5'd1 < {1'b0, cur_len}) begin
        phase_nxt = cur_phase;
        idx_nxt   = idx_r + 4'd1;
        cnt_nxt   = cnt_r + 4'd1;
      end else begin
        phase_nxt = succ_phase;
        idx_nxt   = 4'd0;
        cnt_nxt   = cnt_r + 4'd1;
      end
    end
  end

  // outputs
  assign hex_nibs = {11'd0, job.hex_val};
  assign nib_pos  = 3'(job.main_len - 4'd1 - idx_r);

  always_comb begin
    unique case (cur_phase)
      PH_OPEN:  byte_sel = job.quote;
      PH_FLA:   byte_sel = job.fa_bytes[idx_r[1:0]];
      PH_MAIN: begin
        if (job.main_hex) begin
          if (idx_r == 4'd0) begin
            byte_sel = CH_BSLASH;
          end else if (idx_r == 4'd1) begin
            byte_sel = job.hex_letter;
          end else begin
            byte_sel = hex_char(hex_nibs[nib_pos]);
          end
        end else begin
          byte_sel = job.lit_bytes[idx_r[1:0]];
        end
      end
      PH_FLB:   byte_sel = job.fb_bytes[idx_r[1:0]];
      PH_CLOSE: byte_sel = job.quote;
      default:  byte_sel = job.quote;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_OPEN;
      idx_r       <= 4'd0;
      cnt_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char_r    <= byte_sel;
      run_last_r    <= last;
      string_done_r <= (cur_phase == PH_CLOSE);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_run_last    = run_last_r;
  assign out_string_done = string_done_r;

endmodule

[hw/rtl/utf8_string_repr_escaper.sv]
// Quoted, escaped rendering of a UTF-8 byte string.
// Input channel (in_valid/in_ready): one string byte per request with its
// start/end marks and the quote choice, which is sampled on the start request.
// Output channel (out_valid/out_ready): one rendered byte per request;
// out_run_last marks the final byte produced for an input request and
// out_string_done marks the closing quote. A request yields at most 11 bytes.
// Throughput: one output byte per cycle while out_ready holds, set by the
// single output register fed by the emit sequencer; a request holds the
// sequencer until all its bytes are out, so plain bytes flow at one per cycle
// and escapes (up to 10 bytes for \UHHHHHHHH) hold the input once the request
// queue fills. Bytes that only extend a pending UTF-8 sequence produce nothing
// and push no job. The classifier and emitter are split by a QUEUE_DEPTH-entry
// queue.
// Reset: clears the pending sequence, selects the apostrophe quote and empties
// the queue and output register; no warm-up pass is needed.
// Receiver stall: the output register holds its byte, the emitter waits, and
// in_ready drops once the queue is full; nothing is lost or repeated.
module utf8_string_repr_escaper #(
  parameter int unsigned QUEUE_DEPTH = ure_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_byte_present,
  input  logic       in_starts_string,
  input  logic       in_ends_string,
  input  logic       in_use_double_quote,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_run_last,
  output logic       out_string_done
);
  import ure_pkg::*;

  logic in_accept;
  job_t push_job;
  logic job_push;
  job_t head_job;
  logic head_valid;
  logic q_full;
  logic job_pop;

  assign in_ready  = !q_full;
  assign in_accept = in_valid && in_ready;

  ure_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_accept        (in_accept),
    .data_byte        (in_data_byte),
    .byte_present     (in_byte_present),
    .starts_string    (in_starts_string),
    .ends_string      (in_ends_string),
    .use_double_quote (in_use_double_quote),
    .job              (push_job),
    .job_push         (job_push)
  );

  ure_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_job   (push_job),
    .pop        (job_pop),
    .head_job   (head_job),
    .head_valid (head_valid),
    .full       (q_full)
  );

  ure_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job             (head_job),
    .job_valid       (head_valid),
    .job_pop         (job_pop),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_char        (out_char),
    .out_run_last    (out_run_last),
    .out_string_done (out_string_done)
  );

endmodule
